// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL. They compile to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// clocked check, held off while reset is asserted
`define AST_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// clocked check that also holds during reset
`define AST_ALW(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define AST_RST(lbl, clk, rst_n, prop)
`define AST_ALW(lbl, clk, prop)

`endif

`endif

// ===== sv/rmt_pkg.sv =====
// ----------------------------------------------------------------------------
// rmt_pkg
// Shared widths, defaults and types for the running median tracker.
// ----------------------------------------------------------------------------
package rmt_pkg;

    // default store depth
    localparam int CAPACITY_DEF = 1024;

    // fixed payload widths
    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;

    // what one cell hands to its right-hand neighbor
    typedef struct packed {
        logic                       ge;
        logic signed [SAMPLE_W-1:0] value;
    } t_link;

    // neighboring entry pair around one index: lo = entry i-1, hi = entry i
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
    } t_pair;

endpackage

// ===== sv/rmt_cell.sv =====
// ----------------------------------------------------------------------------
// rmt_cell
// One slot of the sorted chain. On insert it keeps its value, takes the new
// sample, or takes its left neighbor's value, so the row shifts by one slot.
// ----------------------------------------------------------------------------
module rmt_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 11
) (
    input  logic                                 i_clk,
    input  logic                                 i_insert,
    input  logic signed [rmt_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic [CW-1:0]                        i_count,
    input  rmt_pkg::t_link                       i_left,
    output rmt_pkg::t_link                       o_link
);

    localparam logic [CW-1:0] IDX = CW'(INDEX);

    logic signed [rmt_pkg::SAMPLE_W-1:0] r_value;
    logic                                occupied;
    logic                                ge;

    // an empty slot counts as greater than any sample
    assign occupied = (IDX < i_count);
    assign ge       = !occupied || (r_value >= i_sample);

    // shift right from the first slot that is >= the sample
    always_ff @(posedge i_clk) begin
        if (i_insert) begin
            if (i_left.ge) begin
                r_value <= i_left.value;
            end else if (ge) begin
                r_value <= i_sample;
            end
        end
    end

    assign o_link.ge    = ge;
    assign o_link.value = r_value;

endmodule

// ===== sv/rmt_pick_tree.sv =====
// ----------------------------------------------------------------------------
// rmt_pick_tree
// Registered binary mux tree that picks the entry pair at the middle index.
// One level per cycle; the root level is combinational.
// ----------------------------------------------------------------------------
module rmt_pick_tree #(
    parameter int IW = 10
) (
    input  logic              i_clk,
    input  rmt_pkg::t_pair    i_leaf [2**IW],
    input  logic [IW-1:0]     i_mid,
    output rmt_pkg::t_pair    o_root
);

    localparam int P = 2**IW;

    // heap-numbered nodes: 1 is the root, P .. 2P-1 are the leaves
    rmt_pkg::t_pair w_node [1:2*P-1];

    genvar g;
    generate
        for (g = 0; g < P; g++) begin : g_leaf
            assign w_node[P+g] = i_leaf[g];
        end

        for (g = 1; g < P; g++) begin : g_node
            localparam int DEPTH = $clog2(g + 1) - 1;
            localparam int SB    = IW - 1 - DEPTH;
            rmt_pkg::t_pair pick;

            assign pick = i_mid[SB] ? w_node[2*g+1] : w_node[2*g];

            if (g == 1) begin : g_root
                assign w_node[1] = pick;
            end else begin : g_reg
                rmt_pkg::t_pair r_node;

                always_ff @(posedge i_clk) begin
                    r_node <= pick;
                end
                assign w_node[g] = r_node;
            end
        end
    endgenerate

    assign o_root = w_node[1];

endmodule

// ===== sv/running_median_tracker_core.sv =====
// ----------------------------------------------------------------------------
// running_median_tracker_core
// Running median over a bounded sorted chain of cells.
// ----------------------------------------------------------------------------
// Each sample is inserted into a row of CAPACITY cells kept in ascending
// order, in front of the first stored value that is >= it; the row shifts in
// the cycle the beat is accepted. A result beat then carries twice the median
// of the held samples (the middle entry doubled, or the sum of the two middle
// entries), the count held and a dropped flag set when the row was already
// full. The middle pair is read out through a registered mux tree, one level
// per cycle, and the next input beat is not taken until the result of the
// current one is loaded into the output register. A finished result sits in
// the output register while the next sample is accepted and processed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module running_median_tracker_core #(
    parameter int CAPACITY = rmt_pkg::CAPACITY_DEF,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [rmt_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [rmt_pkg::MEDIAN_W-1:0]   o_median_doubled,
    output logic [CW-1:0]                         o_sample_count,
    output logic                                  o_dropped
);

    localparam int IW = $clog2(CAPACITY);
    localparam int P  = 2**IW;
    localparam int SW = (IW > 1) ? $clog2(IW) : 1;
    localparam logic [CW-1:0] FULL = CW'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state                               r_state;
    logic [CW-1:0]                        r_count;
    logic [IW-1:0]                        r_mid;
    logic                                 r_odd;
    logic                                 r_drop;
    logic [SW-1:0]                        r_step;
    logic                                 r_out_valid;
    logic signed [rmt_pkg::MEDIAN_W-1:0]  r_median;
    logic [CW-1:0]                        r_out_count;
    logic                                 r_out_drop;

    logic                                 in_acc;
    logic                                 insert;
    logic [CW-1:0]                        n_count;
    logic                                 last_step;
    logic                                 load_out;
    logic signed [rmt_pkg::MEDIAN_W-1:0]  n_median;

    rmt_pkg::t_link                       link [CAPACITY+1];
    rmt_pkg::t_pair                       leaf [P];
    rmt_pkg::t_pair                       root;

    // input handshake, held off while in reset
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign insert     = in_acc && (r_count != FULL);
    assign n_count    = r_count + CW'(insert);

    // chain of cells; slot 0 has no left neighbor
    assign link[0] = '{ge: 1'b0, value: '0};

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            rmt_cell #(
                .INDEX (g),
                .CW    (CW)
            ) u_cell (
                .i_clk    (i_clk),
                .i_insert (insert),
                .i_sample (i_sample),
                .i_count  (r_count),
                .i_left   (link[g]),
                .o_link   (link[g+1])
            );
        end

        // leaf i carries entries i-1 and i
        for (g = 0; g < P; g++) begin : g_leaf
            if (g < CAPACITY) begin : g_used
                assign leaf[g].lo = (g == 0) ? '0 : link[g].value;
                assign leaf[g].hi = link[g+1].value;
            end else begin : g_pad
                assign leaf[g] = '0;
            end
        end
    endgenerate

    // middle pair read-out
    rmt_pick_tree #(
        .IW (IW)
    ) u_pick (
        .i_clk  (i_clk),
        .i_leaf (leaf),
        .i_mid  (r_mid),
        .o_root (root)
    );

    // doubled median: middle entry twice, or sum of the middle pair
    always_comb begin
        if (r_odd) begin
            n_median = {root.hi, 1'b0};
        end else begin
            n_median = rmt_pkg::MEDIAN_W'(root.lo) + rmt_pkg::MEDIAN_W'(root.hi);
        end
    end

    assign last_step = (r_step == SW'(IW - 1));
    assign load_out  = (r_state == S_WALK) && last_step && (!r_out_valid || !i_out_stall);

    // sequencer, store count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_count <= n_count;
                        r_mid   <= IW'(n_count >> 1);
                        r_odd   <= n_count[0];
                        r_drop  <= !insert;
                        r_step  <= '0;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (load_out) begin
                        r_median    <= n_median;
                        r_out_count <= r_count;
                        r_out_drop  <= r_drop;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (!last_step) begin
                        r_step <= r_step + SW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_median_doubled = r_median;
    assign o_sample_count   = r_out_count;
    assign o_dropped        = r_out_drop;

    // a beat taken with the store full drops the sample and keeps the count
    `AST_RST(a_full_drop, i_clk, i_rst_n, (in_acc && r_count == FULL) |=> (r_drop && $stable(r_count)))
    // the held count never passes the store depth
    `AST_RST(a_count_cap, i_clk, i_rst_n, r_count <= FULL)
    // a result only appears at the end of a read-out walk
    `AST_RST(a_out_after_walk, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_WALK))
    // the tree select index holds for the whole walk
    `AST_RST(a_mid_stable, i_clk, i_rst_n, (r_state == S_WALK && $past(r_state == S_WALK)) |-> $stable(r_mid))

endmodule

// ===== sim/tb_running_median_tracker_core.sv =====
// ----------------------------------------------------------------------------
// tb_running_median_tracker_core
// Self-checking bench for the running median tracker.
// ----------------------------------------------------------------------------
// A short scripted run covers the extremes and equal samples. The random run
// that follows pushes the store past full, so that later samples come back
// dropped. Every accepted sample is run through a sorted-queue model of the
// tracker, and each output beat is checked field by field, oldest first.
// Both sides idle and stall at random, with some calm stretches.
// ----------------------------------------------------------------------------
module tb_running_median_tracker_core;

    localparam int CAP        = rmt_pkg::CAPACITY_DEF;
    localparam int CNT_W      = $clog2(CAP + 1);
    localparam int LAT        = $clog2(CAP) + 1;
    localparam int N_RANDOM   = 1030;
    localparam int CYCLE_CAP  = 800000;
    localparam int N_SCRIPT   = 18;

    typedef logic signed [rmt_pkg::SAMPLE_W-1:0] t_sample;
    typedef logic signed [rmt_pkg::MEDIAN_W-1:0] t_median;

    typedef struct {
        t_median          med;
        logic [CNT_W-1:0] cnt;
        logic             drop;
    } t_result;

    typedef struct {
        t_sample          sample;
        bit               typed;
        t_median          med;
        logic [CNT_W-1:0] cnt;
        logic             drop;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_sample              i_sample;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_median              o_median_doubled;
    logic [CNT_W-1:0]     o_sample_count;
    logic                 o_dropped;

    // model state: held samples in ascending order
    t_sample              sorted_held[$];
    t_result              median_due[$];
    int                   errors = 0;
    int                   cycles = 0;
    int                   stall_left = 0;
    t_sample              last_sample;

    // scripted beats; medians read off directly only where obvious
    // (33'h1_0000_0000 is -2^32, 33'h1_FFFF_FFFF is -1)
    t_row script [N_SCRIPT] = '{
        '{32'sh8000_0000, 1'b1, 33'h1_0000_0000, 11'd1, 1'b0},
        '{32'sh7FFF_FFFF, 1'b1, 33'h1_FFFF_FFFF, 11'd2, 1'b0},
        '{32'sh7FFF_FFFF, 1'b1, 33'h0_FFFF_FFFE, 11'd3, 1'b0},
        '{32'sh8000_0000, 1'b1, 33'h1_FFFF_FFFF, 11'd4, 1'b0},
        '{32'sh0000_0000, 1'b0, '0, '0, 1'b0},
        '{32'sh0000_0000, 1'b0, '0, '0, 1'b0},
        '{32'sh0000_0000, 1'b0, '0, '0, 1'b0},
        '{32'shFFFF_FFFF, 1'b0, '0, '0, 1'b0},
        '{32'sh0000_0001, 1'b0, '0, '0, 1'b0},
        '{32'sh0000_0005, 1'b0, '0, '0, 1'b0},
        '{32'sh0000_0005, 1'b0, '0, '0, 1'b0},
        '{32'shFFFF_FFF9, 1'b0, '0, '0, 1'b0},
        '{32'sh5555_5555, 1'b0, '0, '0, 1'b0},
        '{32'shAAAA_AAAA, 1'b0, '0, '0, 1'b0},
        '{32'sh7FFF_FFFE, 1'b0, '0, '0, 1'b0},
        '{32'sh8000_0001, 1'b0, '0, '0, 1'b0},
        '{32'sh0001_86A0, 1'b0, '0, '0, 1'b0},
        '{32'shFFFE_7960, 1'b0, '0, '0, 1'b0}
    };

    running_median_tracker_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_median_doubled (o_median_doubled),
        .o_sample_count   (o_sample_count),
        .o_dropped        (o_dropped)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cycle count and hang guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("%0t: timeout with %0d results pending", $time, median_due.size());
            $display("[running_median_tracker_core] ERROR");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // insert before the first held value >= sample, then take the doubled median
    function automatic t_result predict_median(input t_sample s);
        t_result res;
        int      pos;
        int      n;
        t_median lo;
        t_median hi;
        res.drop = 1'b0;
        if (sorted_held.size() >= CAP) begin
            res.drop = 1'b1;
        end else begin
            pos = 0;
            while (pos < sorted_held.size() && sorted_held[pos] < s)
                pos++;
            sorted_held.insert(pos, s);
        end
        n = sorted_held.size();
        hi = sorted_held[n / 2];
        lo = (n % 2 == 1) ? hi : t_median'(sorted_held[n / 2 - 1]);
        res.med = lo + hi;
        res.cnt = CNT_W'(n);
        return res;
    endfunction

    // one input beat, after an optional idle stretch
    task automatic send_sample(input t_sample s, input int gap, input bit typed,
                               input t_result typed_res);
        t_result res;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_sample   <= $urandom;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        res = predict_median(s);
        last_sample = s;
        median_due.push_back(typed ? typed_res : res);
    endtask

    // random sample: full range, small clustered values, extremes, repeats
    function automatic t_sample pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return t_sample'($urandom_range(0, 40)) - 20;
            7: begin
                case ($urandom_range(0, 4))
                    0:       return 32'sh8000_0000;
                    1:       return 32'sh7FFF_FFFF;
                    2:       return 32'sh0000_0000;
                    3:       return 32'shFFFF_FFFF;
                    default: return 32'sh0000_0001;
                endcase
            end
            8: begin
                if ($urandom_range(0, 1))
                    return 32'sh7FFF_FFFF - t_sample'($urandom_range(0, 15));
                return 32'sh8000_0000 + t_sample'($urandom_range(0, 15));
            end
            default: return last_sample;
        endcase
    endfunction

    // receiver stall pattern, with calm stretches
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left  <= pick_gap((cycles % 2000) < 300);
        end
    end

    // compare each output beat against the oldest expectation
    always @(posedge i_clk) begin : check_beat
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (median_due.size() == 0) begin
                $display("%0t: unexpected beat median=%0d count=%0d dropped=%0b",
                         $time, o_median_doubled, o_sample_count, o_dropped);
                errors++;
            end else begin
                want = median_due.pop_front();
                if (o_median_doubled !== want.med) begin
                    $display("%0t: median_doubled expected %0d got %0d",
                             $time, want.med, o_median_doubled);
                    errors++;
                end
                if (o_sample_count !== want.cnt) begin
                    $display("%0t: sample_count expected %0d got %0d",
                             $time, want.cnt, o_sample_count);
                    errors++;
                end
                if (o_dropped !== want.drop) begin
                    $display("%0t: dropped expected %0b got %0b",
                             $time, want.drop, o_dropped);
                    errors++;
                end
            end
        end
    end

    // reset, scripted beats, random beats, drain
    initial begin : stimulus
        t_result typed_res;
        int      i;
        last_sample = '0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_SCRIPT; i++) begin
            typed_res.med  = script[i].med;
            typed_res.cnt  = script[i].cnt;
            typed_res.drop = script[i].drop;
            send_sample(script[i].sample, pick_gap(i < 6), script[i].typed, typed_res);
        end

        // random part runs past a full store, so drops show up at the tail
        for (i = 0; i < N_RANDOM; i++) begin
            if (i == 400 || i == 800) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                while (median_due.size() != 0)
                    @(posedge i_clk);
            end
            send_sample(pick_sample(), pick_gap((i % 200) < 30), 1'b0, typed_res);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (median_due.size() != 0)
            @(posedge i_clk);
        repeat (4 * LAT) @(posedge i_clk);

        if (errors == 0 && median_due.size() == 0)
            $display("[running_median_tracker_core] OK");
        else
            $display("[running_median_tracker_core] ERROR");
        $finish;
    end

endmodule

// ===== running_median_tracker_core.f =====
+incdir+sv
sv/rmt_pkg.sv
sv/rmt_cell.sv
sv/rmt_pick_tree.sv
sv/running_median_tracker_core.sv
sim/tb_running_median_tracker_core.sv
